// ===== rtl/i2c_pwm_register_slave_core_macros.svh =====
`ifndef I2C_PWM_REGISTER_SLAVE_CORE_MACROS_SVH
`define I2C_PWM_REGISTER_SLAVE_CORE_MACROS_SVH

// Clocked assertion with reset gating; expects clk and rst_n in scope.
`define IPWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define IPWM_NEVER(lbl, expr, msg) \
  `IPWM_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/ipwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipwm_pkg
// Types, register map constants and reset defaults of the I2C PWM register
// slave.
// ----------------------------------------------------------------------------
package ipwm_pkg;

  localparam int ADDR_W    = 8;
  localparam int REG_DEPTH = 256;

  // Input actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // Result kinds
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Register map
  localparam logic [ADDR_W-1:0] MODE1_ADDR    = 8'd0;
  localparam logic [ADDR_W-1:0] LOW_REG_LIMIT = 8'd6;
  localparam logic [ADDR_W-1:0] FIRST_OFF_H   = 8'd9;
  localparam logic [ADDR_W-1:0] ALL_LED_OFF_H = 8'd253;
  localparam logic [ADDR_W-1:0] PRESCALE_ADDR = 8'd254;
  localparam int                AI_BIT        = 5;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  channel;
    logic [14:0] start_count;
    logic [14:0] off_level;
    logic [7:0]  clock_divider;
    logic [7:0]  read_first;
    logic [7:0]  read_second;
    logic [1:0]  bytes_valid;
    logic        last;
  } out_item_t;

  // Register file access from the control logic
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } rf_req_t;

  typedef struct packed {
    logic [7:0] rdata_a;
    logic [7:0] rdata_b;
  } rf_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_SEND
  } ipwm_state_t;

  typedef enum logic [1:0] {
    MODE_CHAN,
    MODE_ALL,
    MODE_READ
  } ipwm_mode_t;

  // Power-on contents of a register
  function automatic logic [7:0] reg_default(input logic [ADDR_W-1:0] addr);
    logic [7:0] val;
    case (addr)
      8'd0:    val = 8'h88;
      8'd1:    val = 8'h20;
      8'd2:    val = 8'hE2;
      8'd3:    val = 8'hE4;
      8'd4:    val = 8'hE8;
      8'd5:    val = 8'hE0;
      8'd254:  val = 8'hC8;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/ipwm_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipwm_regfile
// 256-byte register file: one write port, two registered read ports.
// Per-entry valid bits stand in for the power-on contents.
// ----------------------------------------------------------------------------
module ipwm_regfile
  import ipwm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  rf_req_t req,
  output rf_rsp_t rsp
);

  logic [7:0]           mem [REG_DEPTH];
  logic [REG_DEPTH-1:0] valid_r;
  logic [7:0]           data_a_r;
  logic [7:0]           data_b_r;
  logic                 vld_a_r;
  logic                 vld_b_r;
  logic [ADDR_W-1:0]    addr_a_r;
  logic [ADDR_W-1:0]    addr_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    data_a_r <= mem[req.raddr_a];
    data_b_r <= mem[req.raddr_b];
    addr_a_r <= req.raddr_a;
    addr_b_r <= req.raddr_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (req.we) begin
        valid_r[req.waddr] <= 1'b1;
      end
      vld_a_r <= valid_r[req.raddr_a];
      vld_b_r <= valid_r[req.raddr_b];
    end
  end

  // Unwritten entries read as their power-on value
  assign rsp.rdata_a = vld_a_r ? data_a_r : reg_default(addr_a_r);
  assign rsp.rdata_b = vld_b_r ? data_b_r : reg_default(addr_b_r);

endmodule

// ===== rtl/i2c_pwm_register_slave_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_pwm_register_slave_core
// Register side of a 16-channel PWM controller behind an I2C slave.
// ----------------------------------------------------------------------------
// One item at a time. A stored byte, a pointer load, a stop or a byte that
// updates no channel is handled in ST_IDLE alone. A channel OFF_H write goes
// through ST_FETCH and ST_LOAD, then sends each update result from ST_SEND
// (the all-LED write sends CHANNELS results back to back while out_stall is
// low). A read goes through ST_LOAD and ST_SEND once per result, READ_BURST/2
// rounded up results in a burst. The register file has two registered read
// ports; output stall holds a result in ST_SEND. The register file needs no
// initialization pass after reset.
module i2c_pwm_register_slave_core
  import ipwm_pkg::*;
#(
  parameter int CHANNELS   = 16,
  parameter int READ_BURST = 70
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int         CH_END  = 9 + 4 * CHANNELS;
  localparam logic [3:0] CH_LAST = 4'(CHANNELS - 1);
  localparam int         IDX_W   = $clog2(READ_BURST + 2);

  ipwm_state_t       state_r, state_nxt;
  ipwm_mode_t        mode_r, mode_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] wptr_r, wptr_nxt;
  logic              ar_r, ar_nxt;
  logic              ai_r, ai_nxt;
  logic              burst_r, burst_nxt;
  logic [7:0]        data_r, data_nxt;
  logic [3:0]        ch_r, ch_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [11:0]       on_r, on_nxt;
  out_item_t         out_r, out_nxt;

  rf_req_t           req;
  rf_rsp_t           rsp;

  logic [ADDR_W-1:0] ptr_m9;
  logic              is_chan;
  logic              is_all;
  logic [11:0]       off12;
  logic              two;

  ipwm_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  function automatic logic [14:0] times_five(input logic [11:0] v);
    return 15'({3'b000, v} << 2) + 15'(v);
  endfunction

  assign ptr_m9  = ptr_r - FIRST_OFF_H;
  assign is_chan = (ptr_r > 8'd8) && (int'(ptr_r) < CH_END) && (ptr_m9[1:0] == 2'b00);
  assign is_all  = (ptr_r == ALL_LED_OFF_H);
  assign off12   = {data_r[3:0], rsp.rdata_a};
  assign two     = (int'(idx_r) + 1) < READ_BURST;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_CHAN;
      ptr_r   <= '0;
      ar_r    <= 1'b0;
      ai_r    <= 1'b0;
      burst_r <= 1'b0;
      ch_r    <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      ptr_r   <= ptr_nxt;
      ar_r    <= ar_nxt;
      ai_r    <= ai_nxt;
      burst_r <= burst_nxt;
      ch_r    <= ch_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wptr_r <= wptr_nxt;
    data_r <= data_nxt;
    on_r   <= on_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    ptr_nxt     = ptr_r;
    wptr_nxt    = wptr_r;
    ar_nxt      = ar_r;
    ai_nxt      = ai_r;
    burst_nxt   = burst_r;
    data_nxt    = data_r;
    ch_nxt      = ch_r;
    idx_nxt     = idx_r;
    on_nxt      = on_r;
    out_nxt     = out_r;
    req.we      = 1'b0;
    req.waddr   = ptr_r;
    req.wdata   = in_data.data_byte;
    req.raddr_a = ptr_r;
    req.raddr_b = ptr_r + 8'd1;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.action)
            ACT_WRITE: begin
              if (!ar_r) begin
                ptr_nxt = in_data.data_byte;
                ar_nxt  = 1'b1;
              end else begin
                req.we   = 1'b1;
                wptr_nxt = ptr_r;
                data_nxt = in_data.data_byte;
                ptr_nxt  = ptr_r + 8'd1;
                if (ptr_r == MODE1_ADDR) begin
                  ai_nxt = in_data.data_byte[AI_BIT];
                end
                if (is_chan || is_all) begin
                  mode_nxt    = is_all ? MODE_ALL : MODE_CHAN;
                  ch_nxt      = is_all ? 4'd0 : ptr_m9[5:2];
                  req.raddr_a = ptr_r - 8'd3;
                  req.raddr_b = ptr_r - 8'd2;
                  state_nxt   = ST_FETCH;
                  if (!ai_r) begin
                    ar_nxt = 1'b0;
                  end
                end
                if (ptr_r < LOW_REG_LIMIT) begin
                  ar_nxt = 1'b0;
                end
              end
            end
            ACT_READ: begin
              ar_nxt    = 1'b0;
              ai_nxt    = 1'b0;
              burst_nxt = ai_r;
              mode_nxt  = MODE_READ;
              idx_nxt   = '0;
              state_nxt = ST_LOAD;
            end
            default: begin
              // stop and the unused code: no effect
            end
          endcase
        end
      end

      ST_FETCH: begin
        on_nxt      = {rsp.rdata_b[3:0], rsp.rdata_a};
        req.raddr_a = wptr_r - 8'd1;
        req.raddr_b = PRESCALE_ADDR;
        state_nxt   = ST_LOAD;
      end

      ST_LOAD: begin
        out_nxt = '0;
        if (mode_r == MODE_READ) begin
          out_nxt.kind       = KIND_READ;
          out_nxt.read_first = rsp.rdata_a;
          if (burst_r) begin
            out_nxt.read_second = two ? rsp.rdata_b : 8'd0;
            out_nxt.bytes_valid = two ? 2'd2 : 2'd1;
            out_nxt.last        = (int'(idx_r) + 2) >= READ_BURST;
          end else begin
            out_nxt.bytes_valid = 2'd1;
            out_nxt.last        = 1'b1;
          end
        end else begin
          out_nxt.kind          = KIND_UPDATE;
          out_nxt.channel       = ch_r;
          out_nxt.start_count   = times_five(on_r);
          out_nxt.off_level     = times_five(off12);
          out_nxt.clock_divider = rsp.rdata_b;
          out_nxt.last          = (mode_r == MODE_CHAN) || (ch_r == CH_LAST);
        end
        state_nxt = ST_SEND;
      end

      ST_SEND: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
          if (!out_r.last) begin
            case (mode_r)
              MODE_READ: begin
                // fetch the next pair of the burst
                idx_nxt     = idx_r + IDX_W'(2);
                req.raddr_a = ptr_r + ADDR_W'(idx_nxt);
                req.raddr_b = ptr_r + ADDR_W'(idx_nxt) + 8'd1;
                state_nxt   = ST_LOAD;
              end
              MODE_ALL: begin
                ch_nxt          = ch_r + 4'd1;
                out_nxt.channel = ch_nxt;
                out_nxt.last    = (ch_nxt == CH_LAST);
                state_nxt       = ST_SEND;
              end
              default: begin
                state_nxt = ST_IDLE;
              end
            endcase
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ipwm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipwm_checker
// Port-level checks of the I2C PWM register slave, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_pwm_register_slave_core_macros.svh"

module ipwm_checker
  import ipwm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic out_held;
  logic stop_taken;
  logic read_out;
  logic update_out;
  logic read_shape_ok;
  logic update_shape_ok;

  assign out_held        = out_valid && out_stall;
  assign stop_taken      = in_valid && !in_stall && in_data.action == ACT_STOP;
  assign read_out        = out_valid && out_data.kind == KIND_READ;
  assign update_out      = out_valid && out_data.kind == KIND_UPDATE;
  assign read_shape_ok   = out_data.channel == 4'd0 && out_data.start_count == 15'd0 &&
                           out_data.bytes_valid != 2'd0;
  assign update_shape_ok = out_data.bytes_valid == 2'd0 && out_data.read_first == 8'd0 &&
                           out_data.start_count <= 15'd20475;

  `IPWM_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_data), "stalled result changed")
  `IPWM_NEVER(a_no_take_while_out, out_valid && !in_stall, "input taken while a result waits")
  `IPWM_ASSERT(a_stop_silent, stop_taken |=> !out_valid, "stop produced a result")
  `IPWM_ASSERT(a_read_shape, read_out |-> read_shape_ok, "malformed read result")
  `IPWM_ASSERT(a_update_shape, update_out |-> update_shape_ok, "malformed update result")

endmodule

bind i2c_pwm_register_slave_core ipwm_checker u_ipwm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== bench/i2c_pwm_register_slave_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_pwm_register_slave_core_test
// Self-checking bench for the I2C PWM register slave. A short table of bus
// transfers (reset reads, pointer loads, full-scale and zero channel writes,
// auto-increment, all-LED write, burst read with wrap) is followed by random
// register sequences. A shadow register map predicts every channel update and
// read result; both sides idle at random.
// ----------------------------------------------------------------------------
module i2c_pwm_register_slave_core_test
  import ipwm_pkg::*;
();

  localparam int CHANNELS       = 16;
  localparam int READ_BURST     = 70;
  localparam int CLK_HALF       = 4;
  localparam int RANDOM_ITEMS   = 125;
  localparam int IDLE_PCT       = 24;
  localparam int CALM_FIRST     = 90;
  localparam int CALM_LAST      = 130;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int DIRECTED_ROWS  = 25;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam logic [7:0] FIRST_ON_L   = 8'd6;
  localparam logic [7:0] ALL_LED_ON_L = 8'd250;

  typedef struct packed {
    in_item_t  item;
    logic      typed_in;
    out_item_t result;
  } stim_row_t;

  localparam out_item_t NO_RESULT = '0;
  localparam out_item_t MODE1_AT_RESET =
    '{KIND_READ, 4'd0, 15'd0, 15'd0, 8'd0, 8'h88, 8'h00, 2'd1, 1'b1};
  localparam out_item_t PRESCALE_AT_RESET =
    '{KIND_READ, 4'd0, 15'd0, 15'd0, 8'd0, 8'hC8, 8'h00, 2'd1, 1'b1};
  localparam out_item_t CH0_FULL_SCALE =
    '{KIND_UPDATE, 4'd0, 15'd20475, 15'd20475, 8'hC8, 8'd0, 8'd0, 2'd0, 1'b1};
  localparam out_item_t CH15_ZERO =
    '{KIND_UPDATE, 4'd15, 15'd0, 15'd0, 8'hC8, 8'd0, 8'd0, 2'd0, 1'b1};

  // Rows without a typed result are checked against the shadow map.
  stim_row_t directed_table [DIRECTED_ROWS] = '{
    '{'{ACT_READ,   8'h00}, 1'b1, MODE1_AT_RESET},
    '{'{ACT_WRITE,  8'd254}, 1'b0, NO_RESULT},
    '{'{ACT_READ,   8'h00}, 1'b1, PRESCALE_AT_RESET},
    '{'{ACT_STOP,   8'hFF}, 1'b0, NO_RESULT},
    '{'{ACT_UNUSED, 8'hFF}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'd6},   1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'hFF}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'hFF}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'hFF}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'hFF}, 1'b1, CH0_FULL_SCALE},
    '{'{ACT_WRITE,  8'd66},  1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'h00}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'h00}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'h00}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'h00}, 1'b1, CH15_ZERO},
    '{'{ACT_WRITE,  8'd1},   1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'h04}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'd0},   1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'hA1}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'd250}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'h34}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'hF1}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'h78}, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,  8'hFA}, 1'b0, NO_RESULT},
    '{'{ACT_READ,   8'h00}, 1'b0, NO_RESULT}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  // Shadow register map
  logic [7:0] pwm_regs [REG_DEPTH];
  logic [7:0] reg_ptr;
  logic       addr_loaded;
  logic       ai_on;

  stim_row_t pending_stim [$];
  out_item_t expected_results [$];
  out_item_t fresh [$];
  stim_row_t in_row;

  int random_items   = 0;
  int items_accepted = 0;
  int updates_seen   = 0;
  int reads_seen     = 0;
  int bursts_sent    = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  logic moved;

  i2c_pwm_register_slave_core #(
    .CHANNELS  (CHANNELS),
    .READ_BURST(READ_BURST)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic out_item_t channel_update(input logic [3:0] ch,
                                               input logic [11:0] on_val,
                                               input logic [11:0] off_val,
                                               input logic [7:0] div,
                                               input logic last);
    out_item_t r;
    r               = '0;
    r.kind          = KIND_UPDATE;
    r.channel       = ch;
    r.start_count   = 15'(on_val) * 15'd5;
    r.off_level     = 15'(off_val) * 15'd5;
    r.clock_divider = div;
    r.last          = last;
    return r;
  endfunction

  function automatic out_item_t read_data(input logic [7:0] b1, input logic [7:0] b2,
                                          input logic [1:0] nb, input logic last);
    out_item_t r;
    r             = '0;
    r.kind        = KIND_READ;
    r.read_first  = b1;
    r.read_second = b2;
    r.bytes_valid = nb;
    r.last        = last;
    return r;
  endfunction

  // Apply one transfer to the shadow map and collect the results it causes.
  task automatic predict_transfer(input in_item_t it);
    logic [7:0]  p;
    logic [11:0] on_val;
    logic [11:0] off_val;
    logic        two;
    int          i;
    fresh.delete();
    case (it.action)
      ACT_WRITE: begin
        if (!addr_loaded) begin
          addr_loaded = 1'b1;
          reg_ptr     = it.data_byte;
        end else begin
          p           = reg_ptr;
          pwm_regs[p] = it.data_byte;
          if (p == MODE1_ADDR) ai_on = it.data_byte[AI_BIT];
          if ((p >= FIRST_OFF_H && p < FIRST_OFF_H + 4 * CHANNELS &&
               2'(p - FIRST_OFF_H) == 2'd0) || p == ALL_LED_OFF_H) begin
            on_val  = {pwm_regs[p - 8'd2][3:0], pwm_regs[p - 8'd3]};
            off_val = {pwm_regs[p][3:0], pwm_regs[p - 8'd1]};
            if (!ai_on) addr_loaded = 1'b0;
            if (p == ALL_LED_OFF_H) begin
              for (i = 0; i < CHANNELS; i++)
                fresh.push_back(channel_update(4'(i), on_val, off_val,
                                               pwm_regs[PRESCALE_ADDR], i == CHANNELS - 1));
            end else begin
              fresh.push_back(channel_update(4'((p - FIRST_OFF_H) >> 2), on_val, off_val,
                                             pwm_regs[PRESCALE_ADDR], 1'b1));
            end
          end
          if (p < LOW_REG_LIMIT) addr_loaded = 1'b0;
          reg_ptr = p + 8'd1;
        end
      end
      ACT_READ: begin
        addr_loaded = 1'b0;
        if (ai_on) begin
          ai_on = 1'b0;
          bursts_sent++;
          for (i = 0; i < READ_BURST; i += 2) begin
            two = (i + 1) < READ_BURST;
            fresh.push_back(read_data(pwm_regs[reg_ptr + 8'(i)],
                                      two ? pwm_regs[reg_ptr + 8'(i + 1)] : 8'd0,
                                      two ? 2'd2 : 2'd1, (i + 2) >= READ_BURST));
          end
        end else begin
          fresh.push_back(read_data(pwm_regs[reg_ptr], 8'd0, 2'd1, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [1:0] act, input logic [7:0] b);
    pending_stim.push_back('{'{act, b}, 1'b0, NO_RESULT});
    if (act == ACT_WRITE || act == ACT_READ) random_items++;
  endtask

  // Queue one random bus sequence; called only when the shadow map is current.
  task automatic build_sequence();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    // drop the stale pointer first, except now and then
    if (addr_loaded && pick < 85 && $urandom_range(0, 3) != 0)
      push_item(ACT_READ, 8'($urandom));
    if (pick < 30) begin
      push_item(ACT_WRITE, FIRST_ON_L + 8'(4 * $urandom_range(0, CHANNELS - 1)));
      k = ($urandom_range(0, 9) == 0) ? 3 : 4;
      repeat (k) push_item(ACT_WRITE, 8'($urandom));
    end else if (pick < 36) begin
      push_item(ACT_WRITE, ALL_LED_ON_L);
      repeat (4) push_item(ACT_WRITE, 8'($urandom));
    end else if (pick < 52) begin
      push_item(ACT_WRITE, $urandom_range(0, 1) ? MODE1_ADDR : PRESCALE_ADDR);
      push_item(ACT_WRITE, 8'($urandom));
    end else if (pick < 68) begin
      push_item(ACT_READ, 8'($urandom));
    end else if (pick < 85) begin
      push_item(ACT_WRITE, 8'($urandom));
      repeat ($urandom_range(1, 6)) push_item(ACT_WRITE, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) push_item(2'($urandom), 8'($urandom));
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing pending: kind %0d channel %0d", got.kind, got.channel);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("channel", want.channel, got.channel);
      compare_field("start_count", want.start_count, got.start_count);
      compare_field("off_level", want.off_level, got.off_level);
      compare_field("clock_divider", want.clock_divider, got.clock_divider);
      compare_field("read_first", want.read_first, got.read_first);
      compare_field("read_second", want.read_second, got.read_second);
      compare_field("bytes_valid", want.bytes_valid, got.bytes_valid);
      compare_field("last", want.last, got.last);
      if (want.kind == KIND_UPDATE) updates_seen++;
      else reads_seen++;
    end
  endtask

  function automatic logic calm_window();
    return items_accepted >= CALM_FIRST && items_accepted < CALM_LAST;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        predict_transfer(in_row.item);
        if (in_row.typed_in) expected_results.push_back(in_row.result);
        else foreach (fresh[j]) expected_results.push_back(fresh[j]);
        items_accepted++;
        moved = 1'b1;
      end
      // hold a stalled transfer, otherwise load the next one or idle
      if (!in_valid || !in_stall) begin
        if (pending_stim.size() == 0 && random_items < RANDOM_ITEMS) build_sequence();
        if (pending_stim.size() != 0 &&
            (calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_row   = pending_stim.pop_front();
          in_valid <= 1'b1;
          in_data  <= in_row.item;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        check_result(out_data);
        moved = 1'b1;
      end
      out_stall <= !calm_window() && $urandom_range(0, 99) < IDLE_PCT;
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("i2c_pwm_register_slave_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (directed_table[r]) pending_stim.push_back(directed_table[r]);
    foreach (pwm_regs[a]) pwm_regs[a] = 8'h00;
    pwm_regs[0]             = 8'h88;
    pwm_regs[1]             = 8'h20;
    pwm_regs[2]             = 8'hE2;
    pwm_regs[3]             = 8'hE4;
    pwm_regs[4]             = 8'hE8;
    pwm_regs[5]             = 8'hE0;
    pwm_regs[PRESCALE_ADDR] = 8'hC8;
    reg_ptr     = 8'd0;
    addr_loaded = 1'b0;
    ai_on       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (pending_stim.size() != 0 || random_items < RANDOM_ITEMS || in_valid ||
           expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d bus transfers accepted (%0d from the directed table)",
             items_accepted, DIRECTED_ROWS);
    $display("%0d channel updates and %0d read results checked, %0d burst reads",
             updates_seen, reads_seen, bursts_sent);
    if (mismatches == 0) begin
      $display("i2c_pwm_register_slave_core verification clean");
    end else begin
      $display("i2c_pwm_register_slave_core verification failed");
    end
    $finish;
  end

endmodule
